@@ rtl/kmpsm_pkg.sv @@
// Shared types for the streaming KMP matcher: action codes and controller states.
package kmpsm_pkg;

   typedef enum logic [1:0] {
      ACT_CLEAR   = 2'd0,
      ACT_APPEND  = 2'd1,
      ACT_TEXT    = 2'd2,
      ACT_RESTART = 2'd3
   } action_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_BUSY = 1'b1
   } state_type;

endpackage

@@ rtl/kmpsm_store.sv @@
// Pattern byte memory and failure table memory, one write port and one registered read each.
module kmpsm_store #(
   parameter int PATTERN_MAX = 64
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [(PATTERN_MAX > 1 ? $clog2(PATTERN_MAX) : 1)-1:0] wr_addr,
   input  logic [7:0]                                  wr_symbol,
   input  logic [(PATTERN_MAX > 1 ? $clog2(PATTERN_MAX) : 1)-1:0] wr_fail,
   input  logic [(PATTERN_MAX > 1 ? $clog2(PATTERN_MAX) : 1)-1:0] rd_addr_pat,
   input  logic [(PATTERN_MAX > 1 ? $clog2(PATTERN_MAX) : 1)-1:0] rd_addr_fail,
   output logic [7:0]                                  rd_symbol,
   output logic [(PATTERN_MAX > 1 ? $clog2(PATTERN_MAX) : 1)-1:0] rd_fail
);

   localparam int AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

   logic [7:0]    pat_mem  [PATTERN_MAX];
   logic [AW-1:0] fail_mem [PATTERN_MAX];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pat_mem[wr_addr]  <= wr_symbol;
         fail_mem[wr_addr] <= wr_fail;
      end
      rd_symbol <= pat_mem[rd_addr_pat];
      rd_fail   <= fail_mem[rd_addr_fail];
   end

endmodule

@@ rtl/kmp_stream_matcher_core.sv @@
// Top level of the streaming KMP matcher: controller, search state and result register.
//
//   Channel   Direction  Handshake               Payload
//   req_      in         req_valid / req_ready   req_action[1:0], req_symbol[7:0]
//   rsp_      out        rsp_valid / rsp_ready   rsp_found, rsp_match_start[31:0],
//                                                rsp_overflow, rsp_searching
//
// Every beat is accepted in the idle state, then committed into the result register from the busy state.
// An appended pattern byte or an active text byte also walks the failure chain before its
// commit; each step is one registered read of the store memories.
// Reset clears the control state only; store entries stay undefined until written,
// and only entries below the pattern count are ever used, so no clearing pass runs.
// A stalled result holds the commit, and a new beat is taken only in the idle state.
module kmp_stream_matcher_core #(
   parameter int PATTERN_MAX  = 64,
   parameter int OFFSET_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_symbol,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic [31:0] rsp_match_start,
   output logic        rsp_overflow,
   output logic        rsp_searching
);

   localparam int AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int LW = $clog2(PATTERN_MAX + 1);
   localparam logic [LW-1:0] PAT_MAX = LW'(PATTERN_MAX);

   kmpsm_pkg::state_type  state_ff, state_in;
   kmpsm_pkg::action_type act_ff, act_in;
   logic [7:0]              sym_ff, sym_in;
   logic [LW-1:0]           len_ff, len_in;
   logic [LW-1:0]           count_ff, count_in;
   logic [LW-1:0]           border_ff, border_in;
   logic [LW-1:0]           matched_ff, matched_in;
   logic [OFFSET_WIDTH-1:0] offset_ff, offset_in;
   logic                    found_ff, found_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_found_ff, rsp_found_in;
   logic [31:0] rsp_match_start_ff, rsp_match_start_in;
   logic        rsp_overflow_ff, rsp_overflow_in;
   logic        rsp_searching_ff, rsp_searching_in;

   logic          accept;
   logic          out_free;
   logic          walk;
   logic          hit;
   logic          walk_done;
   logic          step;
   logic          commit;
   logic [LW-1:0] start_len;
   logic [LW-1:0] k_walk;
   logic [AW-1:0] rd_addr;
   logic [7:0]    pat_q;
   logic [AW-1:0] fail_q;
   logic          wr_en;
   logic [AW-1:0] wr_fail;
   logic [LW-1:0] app_k;
   logic [OFFSET_WIDTH-1:0] start_ow;
   logic [63:0]   start_ext;

   kmpsm_store #(
      .PATTERN_MAX(PATTERN_MAX)
   ) u_store (
      .clock        (clock),
      .wr_en        (wr_en),
      .wr_addr      (count_ff[AW-1:0]),
      .wr_symbol    (sym_ff),
      .wr_fail      (wr_fail),
      .rd_addr_pat  (rd_addr),
      .rd_addr_fail (rd_addr - AW'(1)),
      .rd_symbol    (pat_q),
      .rd_fail      (fail_q)
   );

   // Walk status of the item in flight.
   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      walk      = ((act_ff == kmpsm_pkg::ACT_APPEND) && (count_ff < PAT_MAX) &&
                   (count_ff != '0)) ||
                  ((act_ff == kmpsm_pkg::ACT_TEXT) && (count_ff != '0) && !found_ff);
      hit       = (pat_q == sym_ff);
      walk_done = !walk || hit || (len_ff == '0);
      step      = walk && !walk_done;
      k_walk    = hit ? (len_ff + LW'(1)) : '0;
      start_len = (kmpsm_pkg::action_type'(req_action) == kmpsm_pkg::ACT_TEXT) ?
                  matched_ff : border_ff;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kmpsm_pkg::ST_IDLE: begin
            if (req_valid) state_in = kmpsm_pkg::ST_BUSY;
         end
         kmpsm_pkg::ST_BUSY: begin
            if (walk_done && out_free) state_in = kmpsm_pkg::ST_IDLE;
         end
         default: state_in = kmpsm_pkg::ST_IDLE;
      endcase
   end

   // Controller outputs.
   always_comb begin
      req_ready = 1'b0;
      commit    = 1'b0;
      rd_addr   = len_ff[AW-1:0];
      case (state_ff)
         kmpsm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            rd_addr   = start_len[AW-1:0];
         end
         kmpsm_pkg::ST_BUSY: begin
            commit = walk_done && out_free;
            // A fallback reads the next chain entry straight from the failure data.
            if (step) rd_addr = fail_q;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign accept = req_valid && req_ready;

   // Search state and result updates.
   always_comb begin
      act_in             = act_ff;
      sym_in             = sym_ff;
      len_in             = len_ff;
      count_in           = count_ff;
      border_in          = border_ff;
      matched_in         = matched_ff;
      offset_in          = offset_ff;
      found_in           = found_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_found_in       = rsp_found_ff;
      rsp_match_start_in = rsp_match_start_ff;
      rsp_overflow_in    = rsp_overflow_ff;
      rsp_searching_in   = rsp_searching_ff;
      wr_en              = 1'b0;
      app_k              = (count_ff == '0) ? '0 : k_walk;
      if (app_k > count_ff) app_k = count_ff;
      wr_fail            = app_k[AW-1:0];
      start_ow           = offset_ff - OFFSET_WIDTH'(count_ff) + OFFSET_WIDTH'(1);
      start_ext          = 64'(start_ow);

      if (accept) begin
         act_in = kmpsm_pkg::action_type'(req_action);
         sym_in = req_symbol;
         len_in = start_len;
      end else if (step) begin
         len_in = LW'(fail_q);
      end

      if (commit) begin
         rsp_valid_in       = 1'b1;
         rsp_found_in       = 1'b0;
         rsp_match_start_in = '0;
         rsp_overflow_in    = 1'b0;
         case (act_ff)
            kmpsm_pkg::ACT_CLEAR: begin
               count_in   = '0;
               border_in  = '0;
               matched_in = '0;
               offset_in  = '0;
               found_in   = 1'b0;
            end
            kmpsm_pkg::ACT_APPEND: begin
               if (count_ff >= PAT_MAX) begin
                  rsp_overflow_in = 1'b1;
               end else begin
                  wr_en     = 1'b1;
                  border_in = app_k;
                  count_in  = count_ff + LW'(1);
               end
            end
            kmpsm_pkg::ACT_TEXT: begin
               if ((count_ff != '0) && !found_ff) begin
                  if (k_walk >= count_ff) begin
                     rsp_found_in       = 1'b1;
                     rsp_match_start_in = start_ext[31:0];
                     found_in           = 1'b1;
                     matched_in         = '0;
                  end else begin
                     matched_in = k_walk;
                  end
                  offset_in = offset_ff + OFFSET_WIDTH'(1);
               end
            end
            default: begin
               matched_in = '0;
               offset_in  = '0;
               found_in   = 1'b0;
            end
         endcase
         rsp_searching_in = (count_in != '0) && !found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kmpsm_pkg::ST_IDLE;
         count_ff     <= '0;
         border_ff    <= '0;
         matched_ff   <= '0;
         offset_ff    <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         border_ff    <= border_in;
         matched_ff   <= matched_in;
         offset_ff    <= offset_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff             <= act_in;
      sym_ff             <= sym_in;
      len_ff             <= len_in;
      rsp_found_ff       <= rsp_found_in;
      rsp_match_start_ff <= rsp_match_start_in;
      rsp_overflow_ff    <= rsp_overflow_in;
      rsp_searching_ff   <= rsp_searching_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_match_start = rsp_match_start_ff;
   assign rsp_overflow    = rsp_overflow_ff;
   assign rsp_searching   = rsp_searching_ff;

endmodule

@@ rtl/kmpsm_checker.sv @@
// Port-level checks for the streaming KMP matcher, bound to the top level.
module kmpsm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_found,
   input logic [31:0] rsp_match_start,
   input logic        rsp_overflow,
   input logic        rsp_searching
);

   // A reported occurrence ends the search.
   a_found_not_searching: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> !rsp_searching)
      else $error("found beat still shows searching");

   // The start offset is zero on every beat without a match.
   a_start_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_match_start == 32'd0))
      else $error("nonzero match start without a match");

   // A refused pattern byte cannot also complete a match.
   a_overflow_exclusive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |-> !rsp_found)
      else $error("overflow and found on one beat");

   // The block works on one item at a time, so it is busy right after an accept.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input ready right after an accepted beat");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_found) &&
         $stable(rsp_match_start) && $stable(rsp_overflow) && $stable(rsp_searching)))
      else $error("stalled result beat changed");

endmodule

bind kmp_stream_matcher_core kmpsm_checker u_kmpsm_checker (.*);
